FILE: rtl/lmds_pkg.sv
// Package: shared types and constants for the log magnitude display scaler.
package lmds_pkg;
    localparam int unsigned SAMPLE_BITS_DEF   = 32;
    localparam int unsigned LOG_FRAC_BITS_DEF = 16;
    localparam int unsigned FIFO_DEPTH        = 2;
    localparam int unsigned PIXEL_BITS        = 8;
    localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = 8'd255;

    typedef enum logic {
        OP_SCAN = 1'b0,
        OP_MAP  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_LOG,
        ST_DIV,
        ST_OUT
    } t_state;
endpackage

FILE: rtl/log_magnitude_display_scaler.sv
// Top level: log magnitude display scaler.
//  channel | dir | tdata (low bit up)              | tuser
//  s_axis  | in  | real_part[31:0], imag_part[31:0] | operation, first_of_frame
//  m_axis  | out | pixel[7:0]                       | -
// Back end per beat: an accept state, a bit-pair sqrt, then a min/max update
// for a scan, or for a map the log of magnitude, min and max, a bit-serial
// divide and an output state; one beat at a time, all in one shared unit.
// A two-entry command queue decouples input acceptance from the back end.
// Reset is synchronous, active low; it clears min/max to zero.
// Output stalls hold the back end in its output state.
module log_magnitude_display_scaler
    import lmds_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int unsigned LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // real_part, imag_part
    input  logic [1:0]  s_axis_tuser,   // operation, first_of_frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // pixel
);
    logic                   w_v, w_r, w_first;
    t_op                    w_op;
    logic [SAMPLE_BITS-1:0] w_re, w_im;

    lmds_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(t_op'(s_axis_tuser[0])), .i_first(s_axis_tuser[1]),
        .i_re(s_axis_tdata[31:0]), .i_im(s_axis_tdata[63:32]),
        .o_valid(w_v), .i_ready(w_r), .o_op(w_op), .o_first(w_first),
        .o_re_abs(w_re), .o_im_abs(w_im)
    );

    lmds_back #(.SAMPLE_BITS(SAMPLE_BITS), .LOG_FRAC_BITS(LOG_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_v), .o_ready(w_r), .i_op(w_op), .i_first(w_first),
        .i_re_abs(w_re), .i_im_abs(w_im),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_pixel(m_axis_tdata)
    );
endmodule

FILE: rtl/lmds_front.sv
// Front end: takes input beats, folds components to magnitudes, queues commands.
module lmds_front
    import lmds_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_op                    i_op,
    input  logic                   i_first,
    input  logic [31:0]            i_re,
    input  logic [31:0]            i_im,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_op                    o_op,
    output logic                   o_first,
    output logic [SAMPLE_BITS-1:0] o_re_abs,
    output logic [SAMPLE_BITS-1:0] o_im_abs
);
    localparam int unsigned EW = 2 + 2 * SAMPLE_BITS;

    logic [EW-1:0] r_mem [FIFO_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [SAMPLE_BITS-1:0] w_re, w_im, w_rea, w_ima;
    logic          w_push, w_pop;
    logic [EW-1:0] w_ent;

    assign w_re  = i_re[SAMPLE_BITS-1:0];
    assign w_im  = i_im[SAMPLE_BITS-1:0];
    assign w_rea = w_re[SAMPLE_BITS-1] ? (~w_re + 1'b1) : w_re;
    assign w_ima = w_im[SAMPLE_BITS-1] ? (~w_im + 1'b1) : w_im;
    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_ready;
    assign w_ent   = r_mem[r_rp];
    assign o_op     = t_op'(w_ent[0]);
    assign o_first  = w_ent[1];
    assign o_re_abs = w_ent[2 +: SAMPLE_BITS];
    assign o_im_abs = w_ent[2 + SAMPLE_BITS +: SAMPLE_BITS];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= {w_ima, w_rea, i_first, i_op};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

FILE: rtl/lmds_back.sv
// Back end: sequential sqrt, min/max tracking, Mitchell log and pixel division.
module lmds_back
    import lmds_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int unsigned LOG_FRAC_BITS = LOG_FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  t_op                    i_op,
    input  logic                   i_first,
    input  logic [SAMPLE_BITS-1:0] i_re_abs,
    input  logic [SAMPLE_BITS-1:0] i_im_abs,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [PIXEL_BITS-1:0]  o_pixel
);
    localparam int unsigned AW  = SAMPLE_BITS + 1;      // abs value width
    localparam int unsigned SW  = 2 * AW + 1;           // sum of squares
    localparam int unsigned RW  = (SW + 1) / 2;         // root width
    localparam int unsigned SQI = RW;                   // iterations
    localparam int unsigned CW  = $clog2(SQI + 1);
    localparam int unsigned KW  = 6;
    localparam int unsigned LW  = KW + LOG_FRAC_BITS;
    localparam int unsigned DW  = LW + PIXEL_BITS + 1;

    t_state r_st, n_st;
    logic [SW-1:0] r_rem, n_rem;
    logic [SW-1:0] r_root, n_root;
    logic [SW-1:0] r_sq, n_sq;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_op, n_op;
    logic [31:0]   r_min, n_min, r_max, n_max;
    logic [1:0]    r_lsel, n_lsel;
    logic [LW-1:0] r_lm, n_lm, r_lmin, n_lmin, r_lmax, n_lmax;
    logic [DW-1:0] r_num, n_num;
    logic [DW-1:0] r_den, n_den;
    logic [3:0]    r_q, n_q;
    logic [PIXEL_BITS:0] r_quo, n_quo;
    logic [PIXEL_BITS-1:0] r_pix, n_pix;
    logic          r_ov, n_ov;

    logic [AW-1:0] w_a, w_b;
    logic [2*AW-1:0] w_a2, w_b2;
    logic [SW-1:0] w_trial;
    logic [31:0]   w_m, w_lin;
    logic [32:0]   w_x;
    logic [LW-1:0] w_log;

    function automatic logic [LW-1:0] f_log(input logic [32:0] x);
        logic [KW-1:0] k;
        logic [32:0]   fr;
        logic [LW-1:0] f;
        k = '0;
        for (int i = 0; i < 33; i++) begin
            if (x[i]) k = KW'(i);
        end
        fr = x & ~(33'd1 << k);
        if (k >= KW'(LOG_FRAC_BITS)) f = LW'(fr >> (k - KW'(LOG_FRAC_BITS)));
        else f = LW'(fr << (KW'(LOG_FRAC_BITS) - k));
        return (LW'(k) << LOG_FRAC_BITS) + f;
    endfunction

    assign w_a = {1'b0, i_re_abs};
    assign w_b = {1'b0, i_im_abs};
    assign w_a2 = (2*AW)'(w_a) * (2*AW)'(w_a);
    assign w_b2 = (2*AW)'(w_b) * (2*AW)'(w_b);
    assign w_trial = r_root + r_sq;
    assign w_m  = 32'(r_root);
    assign w_lin = (r_lsel == 2'd0) ? w_m : ((r_lsel == 2'd1) ? r_min : r_max);
    assign w_x  = {1'b0, w_lin} + 33'd1;
    assign w_log = f_log(w_x);

    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = (r_st == ST_OUT);
    assign o_pixel = r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_min <= '0;
            r_max <= '0;
        end else begin
            r_st  <= n_st;
            r_min <= n_min;
            r_max <= n_max;
        end
        r_rem <= n_rem; r_root <= n_root; r_sq <= n_sq; r_cnt <= n_cnt;
        r_op <= n_op; r_lsel <= n_lsel; r_lm <= n_lm; r_lmin <= n_lmin;
        r_lmax <= n_lmax; r_num <= n_num; r_den <= n_den; r_q <= n_q;
        r_quo <= n_quo; r_pix <= n_pix; r_ov <= n_ov;
    end

    // Squares are formed over the accept and first sqrt states: a*a in r_rem, b*b added.
    always_comb begin
        n_st = r_st; n_rem = r_rem; n_root = r_root; n_sq = r_sq; n_cnt = r_cnt;
        n_op = r_op; n_min = r_min; n_max = r_max; n_lsel = r_lsel; n_lm = r_lm;
        n_lmin = r_lmin; n_lmax = r_lmax; n_num = r_num; n_den = r_den;
        n_q = r_q; n_quo = r_quo; n_pix = r_pix; n_ov = r_ov;
        unique case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op   = (i_op == OP_MAP);
                    n_rem  = SW'(w_a2);
                    n_sq   = SW'(w_b2);
                    n_root = '0;
                    n_cnt  = CW'(SQI);
                    n_ov   = i_first;
                    n_st   = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (r_cnt == CW'(SQI)) begin
                    n_rem = r_rem + r_sq;
                    n_sq  = SW'(1) << (2 * (RW - 2));
                    n_cnt = r_cnt - 1'b1;
                end else if (r_cnt != '0) begin
                    if (r_rem >= w_trial) begin
                        n_rem  = r_rem - w_trial;
                        n_root = (r_root >> 1) + r_sq;
                    end else begin
                        n_root = r_root >> 1;
                    end
                    n_sq  = r_sq >> 2;
                    n_cnt = r_cnt - 1'b1;
                end else if (!r_op) begin
                    if (r_ov) begin
                        n_min = w_m; n_max = w_m;
                    end else begin
                        if (w_m < r_min) n_min = w_m;
                        if (w_m > r_max) n_max = w_m;
                    end
                    n_st = ST_IDLE;
                end else begin
                    n_lsel = 2'd0;
                    n_st   = ST_LOG;
                end
            end
            ST_LOG: begin
                unique case (r_lsel)
                    2'd0: n_lm = w_log;
                    2'd1: n_lmin = w_log;
                    default: n_lmax = w_log;
                endcase
                if (r_lsel == 2'd2) begin
                    n_st = ST_DIV;
                    n_cnt = '0;
                    n_q = 4'd9;
                    n_quo = '0;
                    n_pix = '0;
                    n_ov = 1'b0;
                end else begin
                    n_lsel = r_lsel + 2'd1;
                end
            end
            default: begin
                if (r_st == ST_DIV) begin
                    if (r_q == 4'd9) begin
                        if (r_lmax > r_lmin && r_lm > r_lmin) begin
                            n_num = DW'(r_lm - r_lmin) * DW'(PIXEL_MAX);
                            n_den = DW'(r_lmax - r_lmin) << PIXEL_BITS;
                            n_q = 4'd8;
                        end else begin
                            n_st = ST_OUT;
                        end
                    end else if (r_q == 4'd8 && r_num >= (r_den << 1)) begin
                        n_pix = PIXEL_MAX;
                        n_st = ST_OUT;
                    end else begin
                        if (r_num >= r_den) begin
                            n_num = r_num - r_den;
                            n_quo = {r_quo[PIXEL_BITS-1:0], 1'b1};
                        end else begin
                            n_quo = {r_quo[PIXEL_BITS-1:0], 1'b0};
                        end
                        n_den = r_den >> 1;
                        if (r_q == 4'd0) begin
                            n_pix = n_quo[PIXEL_BITS] ? PIXEL_MAX : n_quo[PIXEL_BITS-1:0];
                            n_st = ST_OUT;
                        end else begin
                            n_q = r_q - 4'd1;
                        end
                    end
                end else begin
                    if (i_ready) n_st = ST_IDLE;
                end
            end
        endcase
    end
endmodule

FILE: verif/tb.sv
// Testbench for the log magnitude display scaler: directed and random scan/map beats checked against a model.
`timescale 1ns / 1ps

import lmds_pkg::*;

class pixel_scoreboard;
    logic [31:0] min_mag;
    logic [31:0] max_mag;
    logic [7:0]  pending_pixels[$];
    int          n_errors;
    int          n_pixels;
    int          n_scans;

    function new();
        min_mag = '0;
        max_mag = '0;
        n_errors = 0;
        n_pixels = 0;
        n_scans = 0;
    endfunction

    function automatic logic [63:0] abs32(logic [31:0] v);
        logic [63:0] r;
        r = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        return r;
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [63:0] approx_log2(logic [31:0] v);
        logic [63:0] x;
        logic [63:0] frac;
        int k;
        x = {32'd0, v} + 64'd1;
        k = 0;
        while (k < 63 && (x >> (k + 1)) != 0) k++;
        frac = x - (64'd1 << k);
        if (k >= 16) frac = frac >> (k - 16);
        else frac = frac << (16 - k);
        return (64'(k) << 16) + frac;
    endfunction

    function void note_input(t_op op, logic fof, logic [31:0] re, logic [31:0] im);
        logic [63:0] ar;
        logic [63:0] ai;
        logic [31:0] m;
        logic [63:0] lm;
        logic [63:0] lmin;
        logic [63:0] lmax;
        logic [63:0] q;
        ar = abs32(re);
        ai = abs32(im);
        m = int_sqrt(ar * ar + ai * ai);
        if (op == OP_SCAN) begin
            n_scans++;
            if (fof) begin
                min_mag = m;
                max_mag = m;
            end else begin
                if (m < min_mag) min_mag = m;
                if (m > max_mag) max_mag = m;
            end
        end else begin
            lm = approx_log2(m);
            lmin = approx_log2(min_mag);
            lmax = approx_log2(max_mag);
            q = 0;
            if (lmax > lmin && lm > lmin) begin
                q = (64'd255 * (lm - lmin)) / (lmax - lmin);
                if (q > 255) q = 255;
            end
            pending_pixels.push_back(q[7:0]);
        end
    endfunction

    function void check_pixel(logic [7:0] got);
        logic [7:0] exp_pix;
        n_pixels++;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel beat, actual %0d", $time, got);
            n_errors++;
        end else begin
            exp_pix = pending_pixels.pop_front();
            if (exp_pix !== got) begin
                $display("%0t: pixel expected %0d actual %0d", $time, exp_pix, got);
                n_errors++;
            end
        end
    endfunction
endclass

module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // real_part, imag_part
    logic [1:0]  s_axis_tuser;   // operation, first_of_frame
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // pixel

    pixel_scoreboard pixels;
    int src_idle_pct;
    int snk_stall_pct;
    longint n_cycles;

    log_magnitude_display_scaler uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 2_000_000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) pixels.check_pixel(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_beat(t_op op, logic fof, logic [31:0] re, logic [31:0] im);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {im, re};
        s_axis_tuser <= {fof, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels.note_input(op, fof, re, im);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pixels.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_comp();
        logic [31:0] v;
        int sh;
        case ($urandom_range(4))
            0: v = $urandom;
            1: v = 32'h8000_0000 | $urandom_range(3);
            2: v = $urandom_range(7) - 4;
            default: begin
                sh = $urandom_range(31);
                v = $urandom >> sh;
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic random_frame(int n_scan, int n_map);
        send_beat(OP_SCAN, 1'b1, rand_comp(), rand_comp());
        for (int i = 1; i < n_scan; i++)
            send_beat(OP_SCAN, $urandom_range(15) == 0, rand_comp(), rand_comp());
        for (int i = 0; i < n_map; i++)
            send_beat(OP_MAP, 1'($urandom_range(1)), rand_comp(), rand_comp());
    endtask

    initial begin
        pixels = new();
        n_cycles = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // map before any frame start, then scan without a frame start
        send_beat(OP_MAP, 1'b0, 32'd5, 32'd0);
        send_beat(OP_SCAN, 1'b0, 32'd300, 32'd400);
        send_beat(OP_MAP, 1'b1, 32'd300, 32'd400);
        send_beat(OP_MAP, 1'b0, 32'd0, 32'd0);
        // equal extremes
        send_beat(OP_SCAN, 1'b1, 32'd7, 32'd0);
        send_beat(OP_MAP, 1'b0, 32'd7, 32'd0);
        // full-scale frame
        send_beat(OP_SCAN, 1'b1, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_SCAN, 1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_SCAN, 1'b0, 32'd1000, 32'hFFFF_FC18);
        send_beat(OP_MAP, 1'b0, 32'h8000_0000, 32'h8000_0000);
        send_beat(OP_MAP, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(OP_MAP, 1'b0, 32'd0, 32'd0);
        send_beat(OP_MAP, 1'b0, 32'hFFFF_FFFF, 32'd1);
        // below minimum and above maximum
        send_beat(OP_SCAN, 1'b1, 32'd100, 32'd0);
        send_beat(OP_SCAN, 1'b0, 32'd0, 32'd200);
        send_beat(OP_MAP, 1'b0, 32'd3, 32'd4);
        send_beat(OP_MAP, 1'b0, 32'd150, 32'd0);
        send_beat(OP_MAP, 1'b0, 32'h4000_0000, 32'hC000_0000);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 31 : 0;
            snk_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 31 : 0;
            for (int f = 0; f < 18; f++) begin
                random_frame($urandom_range(1, 8), $urandom_range(1, 12));
                if ($urandom_range(4) == 0)
                    send_beat(t_op'($urandom_range(1)), 1'($urandom_range(1)),
                              $urandom, $urandom);
            end
            drain();
        end
        snk_stall_pct = 0;
        drain();

        $display("Covered %0d scan beats and %0d pixel beats over four idle/stall mixes,",
                 pixels.n_scans, pixels.n_pixels);
        $display("including unset, equal, below-min and above-max extremes.");
        if (pixels.n_errors == 0 && pixels.pending_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
